/* src/tsl_pkg.sv */
package tsl_pkg;

  localparam int AXIS_W  = 16;
  localparam int DZ_W    = 15;
  localparam int MAG_W   = 24;
  localparam int DT_W    = 20;
  localparam int OUT_W   = 25;
  localparam int VEL_W   = 26;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;

  localparam int IN_TDATA_W  = 72;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 80;

  localparam logic [CFG_IDX_W-1:0] REG_DEADZONE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_VELOCITY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACCELERATION = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DECELERATION = 3'd3;

  typedef struct packed {
    logic advance;
    logic clear;
  } lane_ctl_t;

endpackage

/* src/tsl_lane.sv */
module tsl_lane (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            load,
  input  logic [tsl_pkg::AXIS_W-1:0]      axis_i,
  input  logic [tsl_pkg::DZ_W-1:0]        deadzone_i,
  input  logic [tsl_pkg::MAG_W-1:0]       max_vel_i,
  input  tsl_pkg::lane_ctl_t              ctl_i,
  input  logic [tsl_pkg::MAG_W-1:0]       acc_step_i,
  input  logic [tsl_pkg::MAG_W-1:0]       dec_step_i,
  output logic [tsl_pkg::OUT_W-1:0]       vel_o
);

  localparam int PROD_W = tsl_pkg::DZ_W + tsl_pkg::MAG_W;
  localparam int ERR_W  = tsl_pkg::VEL_W + 1;

  logic [tsl_pkg::AXIS_W-1:0] abs_axis;
  logic [tsl_pkg::DZ_W-1:0]   dmag;
  logic [tsl_pkg::DZ_W-1:0]   dmag_dz;
  logic [PROD_W-1:0]          prod;
  logic [tsl_pkg::MAG_W-1:0]  tmag;
  logic [tsl_pkg::OUT_W-1:0]  tmag_ext;
  logic [tsl_pkg::OUT_W-1:0]  tgt_nxt;
  logic [tsl_pkg::OUT_W-1:0]  tgt_r;

  logic [tsl_pkg::VEL_W-1:0]  vel_r;
  logic [tsl_pkg::VEL_W-1:0]  vel_nxt;
  logic [tsl_pkg::VEL_W-1:0]  slew_val;
  logic [tsl_pkg::VEL_W-1:0]  cur_mag;
  logic [tsl_pkg::OUT_W-1:0]  tgt_abs;
  logic [tsl_pkg::VEL_W-1:0]  tgt_mag;
  logic                       slowing;
  logic [tsl_pkg::MAG_W-1:0]  step;
  logic [ERR_W-1:0]           err;
  logic [ERR_W-1:0]           err_mag;

  // target: clamp, deadzone, scale
  always_comb begin
    abs_axis = axis_i[tsl_pkg::AXIS_W-1] ? (~axis_i + 1'b1) : axis_i;
    if (axis_i == {1'b1, {(tsl_pkg::AXIS_W-1){1'b0}}}) begin
      dmag = '1;
    end else begin
      dmag = abs_axis[tsl_pkg::DZ_W-1:0];
    end
    dmag_dz  = (dmag < deadzone_i) ? '0 : dmag;
    prod     = PROD_W'(dmag_dz) * PROD_W'(max_vel_i);
    tmag     = prod[PROD_W-1:tsl_pkg::DZ_W];
    tmag_ext = {1'b0, tmag};
    tgt_nxt  = axis_i[tsl_pkg::AXIS_W-1] ? (~tmag_ext + 1'b1) : tmag_ext;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tgt_r <= tgt_nxt;
    end
  end

  // slew toward target
  always_comb begin
    cur_mag = vel_r[tsl_pkg::VEL_W-1] ? (~vel_r + 1'b1) : vel_r;
    tgt_abs = tgt_r[tsl_pkg::OUT_W-1] ? (~tgt_r + 1'b1) : tgt_r;
    tgt_mag = {1'b0, tgt_abs};
    slowing = (tgt_mag < cur_mag)
            || (tgt_r[tsl_pkg::OUT_W-1] && !vel_r[tsl_pkg::VEL_W-1] && (vel_r != '0))
            || (!tgt_r[tsl_pkg::OUT_W-1] && (tgt_r != '0) && vel_r[tsl_pkg::VEL_W-1]);
    step    = slowing ? dec_step_i : acc_step_i;
    err     = {{2{tgt_r[tsl_pkg::OUT_W-1]}}, tgt_r} - {vel_r[tsl_pkg::VEL_W-1], vel_r};
    err_mag = err[ERR_W-1] ? (~err + 1'b1) : err;
    if (err_mag <= ERR_W'(step)) begin
      slew_val = {tgt_r[tsl_pkg::OUT_W-1], tgt_r};
    end else if (err[ERR_W-1]) begin
      slew_val = vel_r - tsl_pkg::VEL_W'(step);
    end else begin
      slew_val = vel_r + tsl_pkg::VEL_W'(step);
    end
    if (ctl_i.clear) begin
      vel_nxt = '0;
    end else if (ctl_i.advance) begin
      vel_nxt = slew_val;
    end else begin
      vel_nxt = vel_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vel_r <= '0;
    end else begin
      vel_r <= vel_nxt;
    end
  end

  assign vel_o = vel_nxt[tsl_pkg::OUT_W-1:0];

endmodule

/* src/tsl_merge.sv */
module tsl_merge #(
  parameter int DEPTH = 4
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               push,
  input  logic [tsl_pkg::OUT_W-1:0]          x_i,
  input  logic [tsl_pkg::OUT_W-1:0]          y_i,
  input  logic [tsl_pkg::OUT_W-1:0]          z_i,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [tsl_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic [$clog2(DEPTH+1)-1:0]         level
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int PAD_W = tsl_pkg::OUT_TDATA_W - 3 * tsl_pkg::OUT_W;

  logic [tsl_pkg::OUT_TDATA_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             pop;

  assign pop        = out_tvalid && out_tready;
  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = mem[rd_ptr_r];
  assign level      = cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= {{PAD_W{1'b0}}, z_i, y_i, x_i};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

/* src/three_axis_velocity_slew_limiter.sv */
// Three-axis velocity slew limiter: one input beat per clock while in_tready
// is high. Stage one clamps each stick axis, applies the deadzone, scales
// to a Q8.16 target and forms acceleration*dt and deceleration*dt; stage
// two runs the per-axis slew against the velocity register, which is a
// single compare/add loop per cycle and sets the rate.
// Results collect in an OUT_DEPTH beat output queue; in_tready drops only
// while that queue plus the beat in flight would overflow it.
module three_axis_velocity_slew_limiter #(
  parameter int OUT_DEPTH = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // forward_axis, strafe_axis, turn_axis, time_step, zero pad
  input  logic [tsl_pkg::IN_TDATA_W-1:0]    in_tdata,
  // func, motion enable
  input  logic [tsl_pkg::IN_TUSER_W-1:0]    in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // forward velocity, strafe velocity, turn rate, zero pad
  output logic [tsl_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tsl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tsl_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int CNT_W  = $clog2(OUT_DEPTH + 1);
  localparam int SPROD_W = tsl_pkg::MAG_W + tsl_pkg::DT_W;

  logic [tsl_pkg::DZ_W-1:0]  deadzone_r;
  logic [tsl_pkg::MAG_W-1:0] max_velocity_r;
  logic [tsl_pkg::MAG_W-1:0] acceleration_r;
  logic [tsl_pkg::MAG_W-1:0] deceleration_r;

  logic                      in_acc;
  logic [CNT_W-1:0]          level;
  logic [tsl_pkg::DT_W-1:0]  time_step;
  logic [SPROD_W-1:0]        acc_prod;
  logic [SPROD_W-1:0]        dec_prod;

  logic                      a_valid_r;
  logic                      a_func_r;
  logic                      a_motion_r;
  logic [tsl_pkg::MAG_W-1:0] acc_step_r;
  logic [tsl_pkg::MAG_W-1:0] dec_step_r;
  logic                      driving_r;
  logic                      driving_nxt;

  tsl_pkg::lane_ctl_t        ctl;
  logic                      push;
  logic [tsl_pkg::OUT_W-1:0] vel_x;
  logic [tsl_pkg::OUT_W-1:0] vel_y;
  logic [tsl_pkg::OUT_W-1:0] vel_z;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadzone_r     <= '0;
      max_velocity_r <= '0;
      acceleration_r <= '0;
      deceleration_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tsl_pkg::REG_DEADZONE:     deadzone_r     <= cfg_data[tsl_pkg::DZ_W-1:0];
        tsl_pkg::REG_MAX_VELOCITY: max_velocity_r <= cfg_data;
        tsl_pkg::REG_ACCELERATION: acceleration_r <= cfg_data;
        tsl_pkg::REG_DECELERATION: deceleration_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_tready = ((CNT_W + 1)'(level) + (CNT_W + 1)'(a_valid_r))
                     < (CNT_W + 1)'(OUT_DEPTH);
  assign in_acc    = in_tvalid && in_tready;

  assign time_step = in_tdata[67:48];
  assign acc_prod  = SPROD_W'(acceleration_r) * SPROD_W'(time_step);
  assign dec_prod  = SPROD_W'(deceleration_r) * SPROD_W'(time_step);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      driving_r <= 1'b0;
    end else begin
      a_valid_r <= in_acc;
      driving_r <= driving_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_func_r   <= in_tuser[0];
      a_motion_r <= in_tuser[1];
      acc_step_r <= acc_prod[SPROD_W-1:tsl_pkg::DT_W];
      dec_step_r <= dec_prod[SPROD_W-1:tsl_pkg::DT_W];
    end
  end

  always_comb begin
    ctl.clear   = a_valid_r && a_func_r;
    ctl.advance = a_valid_r && !a_func_r && a_motion_r;
    push        = ctl.advance || (ctl.clear && driving_r);
    if (ctl.clear) begin
      driving_nxt = 1'b0;
    end else if (ctl.advance) begin
      driving_nxt = 1'b1;
    end else begin
      driving_nxt = driving_r;
    end
  end

  tsl_lane u_lane_x (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (in_acc),
    .axis_i     (in_tdata[15:0]),
    .deadzone_i (deadzone_r),
    .max_vel_i  (max_velocity_r),
    .ctl_i      (ctl),
    .acc_step_i (acc_step_r),
    .dec_step_i (dec_step_r),
    .vel_o      (vel_x)
  );

  tsl_lane u_lane_y (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (in_acc),
    .axis_i     (in_tdata[31:16]),
    .deadzone_i (deadzone_r),
    .max_vel_i  (max_velocity_r),
    .ctl_i      (ctl),
    .acc_step_i (acc_step_r),
    .dec_step_i (dec_step_r),
    .vel_o      (vel_y)
  );

  tsl_lane u_lane_z (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (in_acc),
    .axis_i     (in_tdata[47:32]),
    .deadzone_i (deadzone_r),
    .max_vel_i  (max_velocity_r),
    .ctl_i      (ctl),
    .acc_step_i (acc_step_r),
    .dec_step_i (dec_step_r),
    .vel_o      (vel_z)
  );

  tsl_merge #(
    .DEPTH (OUT_DEPTH)
  ) u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .x_i        (vel_x),
    .y_i        (vel_y),
    .z_i        (vel_z),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .level      (level)
  );

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;

  typedef enum logic {FN_STEP = 1'b0, FN_STOP = 1'b1} func_t;

  typedef struct {
    logic [tsl_pkg::OUT_W-1:0] lin_x;
    logic [tsl_pkg::OUT_W-1:0] lin_y;
    logic [tsl_pkg::OUT_W-1:0] ang_z;
  } vel_cmd_t;

  localparam logic [tsl_pkg::CFG_IDX_W-1:0] REG_NONE = 3'd7;
  localparam longint AXIS_FULL = 32767;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 3000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [tsl_pkg::IN_TDATA_W-1:0] in_tdata = '0;
  logic [tsl_pkg::IN_TUSER_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [tsl_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [tsl_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [tsl_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // predictor state
  logic [tsl_pkg::DZ_W-1:0] lim_deadzone = '0;
  logic [tsl_pkg::MAG_W-1:0] lim_max_vel = '0;
  logic [tsl_pkg::MAG_W-1:0] lim_accel = '0;
  logic [tsl_pkg::MAG_W-1:0] lim_decel = '0;
  longint vel_fwd = 0;
  longint vel_str = 0;
  longint vel_trn = 0;
  bit driving_now = 0;

  vel_cmd_t pending_cmds[$];
  vel_cmd_t want_cmd;
  int mismatches = 0;
  int stalled = 0;
  bit tx_gaps = 1;
  logic rx_gaps = 1'b1;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;

  three_axis_velocity_slew_limiter u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint axis_target(logic [tsl_pkg::AXIS_W-1:0] raw);
    longint d;
    longint m;
    d = longint'($signed(raw));
    if (d > AXIS_FULL) d = AXIS_FULL;
    if (d < -AXIS_FULL) d = -AXIS_FULL;
    if (mag(d) < longint'(lim_deadzone)) d = 0;
    m = (mag(d) * longint'(lim_max_vel)) >>> 15;
    return d < 0 ? -m : m;
  endfunction

  function automatic longint slew_toward(longint cur, longint tgt,
                                         logic [tsl_pkg::DT_W-1:0] dt);
    bit slowing;
    longint rate;
    longint lim;
    longint err;
    slowing = mag(tgt) < mag(cur) || (tgt < 0 && cur > 0) || (tgt > 0 && cur < 0);
    rate = slowing ? longint'(lim_decel) : longint'(lim_accel);
    lim = (rate * longint'(dt)) >>> 20;
    err = tgt - cur;
    if (mag(err) <= lim) return tgt;
    return err < 0 ? cur - lim : cur + lim;
  endfunction

  task automatic predict_velocity(input func_t fn, input logic allow,
                                  input logic [tsl_pkg::AXIS_W-1:0] fwd,
                                  input logic [tsl_pkg::AXIS_W-1:0] str,
                                  input logic [tsl_pkg::AXIS_W-1:0] trn,
                                  input logic [tsl_pkg::DT_W-1:0] dt);
    vel_cmd_t cmd;
    bit prev_driving;
    if (fn == FN_STOP) begin
      prev_driving = driving_now;
      driving_now = 0;
      vel_fwd = 0;
      vel_str = 0;
      vel_trn = 0;
      if (!prev_driving) return;
    end else begin
      if (!allow) return;
      vel_fwd = slew_toward(vel_fwd, axis_target(fwd), dt);
      vel_str = slew_toward(vel_str, axis_target(str), dt);
      vel_trn = slew_toward(vel_trn, axis_target(trn), dt);
      driving_now = 1;
    end
    cmd.lin_x = vel_fwd[tsl_pkg::OUT_W-1:0];
    cmd.lin_y = vel_str[tsl_pkg::OUT_W-1:0];
    cmd.ang_z = vel_trn[tsl_pkg::OUT_W-1:0];
    pending_cmds = {pending_cmds, cmd};
  endtask

  // call right after a rising edge
  task automatic send_beat(input func_t fn, input logic allow,
                           input logic [tsl_pkg::AXIS_W-1:0] fwd,
                           input logic [tsl_pkg::AXIS_W-1:0] str,
                           input logic [tsl_pkg::AXIS_W-1:0] trn,
                           input logic [tsl_pkg::DT_W-1:0] dt);
    if (tx_gaps) begin
      while ($urandom_range(99) < 24) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'b0, dt, trn, str, fwd};
    in_tuser <= {allow, fn};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_velocity(fn, allow, fwd, str, trn, dt);
  endtask

  task automatic write_reg(input logic [tsl_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tsl_pkg::CFG_DATA_W-1:0] val);
    in_tvalid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      tsl_pkg::REG_DEADZONE:     lim_deadzone = val[tsl_pkg::DZ_W-1:0];
      tsl_pkg::REG_MAX_VELOCITY: lim_max_vel = val;
      tsl_pkg::REG_ACCELERATION: lim_accel = val;
      tsl_pkg::REG_DECELERATION: lim_decel = val;
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [tsl_pkg::DZ_W-1:0] dz,
                          input logic [tsl_pkg::MAG_W-1:0] mv,
                          input logic [tsl_pkg::MAG_W-1:0] ac,
                          input logic [tsl_pkg::MAG_W-1:0] dc);
    write_reg(tsl_pkg::REG_DEADZONE, {9'd0, dz});
    write_reg(tsl_pkg::REG_MAX_VELOCITY, mv);
    write_reg(tsl_pkg::REG_ACCELERATION, ac);
    write_reg(tsl_pkg::REG_DECELERATION, dc);
  endtask

  function automatic logic [tsl_pkg::MAG_W-1:0] rand_reg(int w);
    int k;
    logic [31:0] mask;
    k = int'($urandom_range(w, 1));
    mask = (32'd1 << k) - 32'd1;
    return tsl_pkg::MAG_W'($urandom & mask);
  endfunction

  function automatic logic [tsl_pkg::AXIS_W-1:0] pick_axis();
    int v;
    case ($urandom_range(5))
      3: begin
        case ($urandom_range(3))
          0: v = -32768;
          1: v = 32767;
          2: v = -32767;
          default: v = 0;
        endcase
      end
      4: begin
        v = int'(lim_deadzone) - 1 + int'($urandom_range(2));
        if ($urandom_range(1)) v = -v;
      end
      default: v = int'($urandom);
    endcase
    return v[tsl_pkg::AXIS_W-1:0];
  endfunction

  function automatic logic [tsl_pkg::DT_W-1:0] pick_dt();
    case ($urandom_range(3))
      0: return tsl_pkg::DT_W'($urandom_range(255));
      1: return $urandom_range(1) ? {tsl_pkg::DT_W{1'b1}} : '0;
      default: return tsl_pkg::DT_W'($urandom);
    endcase
  endfunction

  // mostly live steps; some stops and dropped steps mixed in
  task automatic send_random(output bit counted);
    int kind;
    func_t fn;
    logic allow;
    kind = int'($urandom_range(99));
    allow = 1'($urandom_range(1));
    fn = FN_STEP;
    if (kind < 6) fn = FN_STOP;
    else if (kind < 14) allow = 1'b0;
    else allow = 1'b1;
    counted = (fn == FN_STOP) || allow;
    send_beat(fn, allow, pick_axis(), pick_axis(), pick_axis(), pick_dt());
  endtask

  task automatic test_reset_defaults();
    send_beat(FN_STOP, 1'b1, 16'h7FFF, 16'h8000, 16'h0001, 20'hFFFFF);
    send_beat(FN_STEP, 1'b1, 16'h7FFF, 16'h8000, 16'h0001, 20'hFFFFF);
    send_beat(FN_STOP, 1'b0, 16'h0000, 16'h0000, 16'h0000, 20'h00000);
  endtask

  task automatic test_directed();
    set_regs(15'd1000, 24'hFFFFFF, 24'h100000, 24'h200000);
    send_beat(FN_STOP, 1'b0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 20'hFFFFF);
    send_beat(FN_STEP, 1'b0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 20'hFFFFF);
    send_beat(FN_STEP, 1'b1, 16'h7FFF, 16'h8000, 16'h0000, 20'hFFFFF);
    send_beat(FN_STEP, 1'b1, 16'h7FFF, 16'h8000, 16'h0000, 20'hFFFFF);
    // deadzone edges with a zero, then a one-LSB time step
    send_beat(FN_STEP, 1'b1, 16'd999, -16'sd999, 16'd1000, 20'd0);
    send_beat(FN_STEP, 1'b1, -16'sd1000, 16'd1000, -16'sd1001, 20'd1);
    // reversal and slowing
    send_beat(FN_STEP, 1'b1, 16'h8001, 16'd5000, 16'hFFFF, 20'h80000);
    send_beat(FN_STEP, 1'b1, 16'h8001, 16'd5000, 16'h0001, 20'hFFFFF);
    send_beat(FN_STOP, 1'b1, 16'h0000, 16'h0000, 16'h0000, 20'd0);
    send_beat(FN_STOP, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 20'hFFFFF);
    send_beat(FN_STEP, 1'b1, 16'h0000, 16'h0000, 16'h0000, 20'd0);
    set_regs(15'd0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send_beat(FN_STEP, 1'b1, 16'h7FFF, 16'h8001, 16'h8000, 20'hFFFFF);
    send_beat(FN_STEP, 1'b1, 16'h8000, 16'h7FFF, 16'h0001, 20'hFFFFF);
    send_beat(FN_STEP, 1'b1, 16'hFFFF, 16'h0000, 16'h7FFF, 20'hFFFFF);
  endtask

  task automatic test_unused_index();
    set_regs(15'd200, 24'h012345, 24'h00F000, 24'h030000);
    write_reg(REG_NONE, 24'hFFFFFF);
    send_beat(FN_STEP, 1'b1, 16'h4000, 16'hC000, 16'd199, 20'h40000);
    send_beat(FN_STEP, 1'b1, 16'hC000, 16'h4000, 16'd200, 20'h40000);
  endtask

  task automatic test_backpressure();
    bit counted;
    tx_gaps = 0;
    hold_reqs <= hold_reqs + 1;
    repeat (40) send_random(counted);
    tx_gaps = 1;
  endtask

  task automatic test_random();
    bit counted;
    int done;
    int goal;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_regs(15'd0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        1: set_regs(15'h7FFF, 24'hFFFFFF, 24'h000100, 24'h000100);
        2: set_regs(15'd0, 24'd0, 24'd0, 24'd0);
        default: set_regs(tsl_pkg::DZ_W'(rand_reg(tsl_pkg::DZ_W)),
                          rand_reg(tsl_pkg::MAG_W), rand_reg(tsl_pkg::MAG_W),
                          rand_reg(tsl_pkg::MAG_W));
      endcase
      tx_gaps = (ph != 3);
      rx_gaps <= (ph != 3);
      goal = (ph == 2) ? 30 : 80;
      done = 0;
      while (done < goal) begin
        send_random(counted);
        done += counted;
      end
    end
    tx_gaps = 1;
    rx_gaps <= 1'b1;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= rx_gaps ? ($urandom_range(99) >= 24) : 1'b1;
    end
  end

  task automatic check_field(input string name, input logic [tsl_pkg::OUT_W-1:0] want,
                             input logic [tsl_pkg::OUT_W-1:0] got);
    if (got !== want) begin
      if (mismatches < 10)
        $display("mismatch %s: expected %0d, got %0d", name, $signed(want), $signed(got));
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_cmds.size() == 0) begin
        if (mismatches < 10) $display("unexpected beat: %h", out_tdata);
        mismatches++;
      end else begin
        want_cmd = pending_cmds.pop_front();
        check_field("fwd_vel", want_cmd.lin_x, out_tdata[24:0]);
        check_field("side_vel", want_cmd.lin_y, out_tdata[49:25]);
        check_field("turn_rate", want_cmd.ang_z, out_tdata[74:50]);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      stalled <= 0;
    end else if (stalled >= STALL_LIMIT) begin
      $display("timeout: no beat moved in %0d cycles", STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      stalled <= stalled + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_directed();
    test_unused_index();
    test_backpressure();
    test_random();
    in_tvalid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_cmds.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
